[src/erms_pkg.sv]
// Shared types and constants for the e-paper refresh mode selector.
`default_nettype none
package erms_pkg;

    // Refresh decision carried in the low bits of each result item.
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PARTIAL = 2'd1,
        ACT_FULL    = 2'd2
    } action_t;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_FRAME_LENGTH   = 2'd0;
    localparam logic [1:0] REG_DIRTY_PERCENT  = 2'd1;
    localparam logic [1:0] REG_PARTIAL_LIMIT  = 2'd2;

    // Fixed field widths.
    localparam int FRAME_LENGTH_W  = 18;
    localparam int PERCENT_W       = 7;
    localparam int RUN_W           = 8;
    localparam int COUNT_W         = 18;
    localparam int BYTE_W          = 8;
    localparam int LHS_W           = COUNT_W + PERCENT_W;

    // Register reset values.
    localparam logic [FRAME_LENGTH_W-1:0] FRAME_LENGTH_RST = 18'd48000;
    localparam logic [PERCENT_W-1:0]      DIRTY_PERCENT_RST = 7'd50;
    localparam logic [RUN_W-1:0]          PARTIAL_LIMIT_RST = 8'd10;

    localparam logic [PERCENT_W-1:0] PERCENT_SCALE = 7'd100;

endpackage : erms_pkg
`default_nettype wire

[src/epaper_refresh_mode_selector.sv]
// Top level of the e-paper refresh mode selector: frame store, change counter and decision.
`default_nettype none
// Framebuffer bytes enter on the s_ side one per item, in address order. Each
// byte is compared with the byte of the previous frame held in a
// single-port-per-direction frame store (one read and one write each cycle,
// registered read data) and written back; a byte that follows a write to
// the same address is forwarded. After the last byte of a frame, one result
// item with the refresh decision and the changed-byte count appears on the
// m_ side once it has passed stages A, P and Q and the output register. The
// byte that ends a frame is taken only when no earlier result is still
// pending in the decision pipeline or the output register, so frames of five
// bytes or more run at one byte per cycle when the output is taken at once.
// The frame store needs no clearing pass; it holds valid data for every
// address a previous frame has written.
module epaper_refresh_mode_selector #(
    parameter int MAX_FRAME_BYTES = 131072
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Byte stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
    // Result stream out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // [1:0] refresh_action, [19:2] changed_bytes, [23:20] 0
);

    localparam int AW  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int LW  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES + 1) : 1;
    localparam int LCW = (LW > erms_pkg::FRAME_LENGTH_W) ? LW : erms_pkg::FRAME_LENGTH_W;
    localparam int RW  = LW + erms_pkg::RUN_W;
    localparam int CW  = (RW > erms_pkg::LHS_W) ? RW : erms_pkg::LHS_W;

    // Configuration registers.
    logic [erms_pkg::FRAME_LENGTH_W-1:0] frame_length_reg;
    logic [erms_pkg::PERCENT_W-1:0]      dirty_percent_reg;
    logic [erms_pkg::RUN_W-1:0]          partial_limit_reg;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg  <= erms_pkg::FRAME_LENGTH_RST;
            dirty_percent_reg <= erms_pkg::DIRTY_PERCENT_RST;
            partial_limit_reg <= erms_pkg::PARTIAL_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                erms_pkg::REG_FRAME_LENGTH:
                    frame_length_reg  <= pwdata[erms_pkg::FRAME_LENGTH_W-1:0];
                erms_pkg::REG_DIRTY_PERCENT:
                    dirty_percent_reg <= pwdata[erms_pkg::PERCENT_W-1:0];
                erms_pkg::REG_PARTIAL_LIMIT:
                    partial_limit_reg <= pwdata[erms_pkg::RUN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            erms_pkg::REG_FRAME_LENGTH:  prdata = 32'(frame_length_reg);
            erms_pkg::REG_DIRTY_PERCENT: prdata = 32'(dirty_percent_reg);
            erms_pkg::REG_PARTIAL_LIMIT: prdata = 32'(partial_limit_reg);
            default:                     prdata = 32'd0;
        endcase
    end

    // Effective frame length: zero acts as one, and it saturates at the store depth.
    logic [LCW-1:0] fl_ext;
    logic [LCW-1:0] len_ext;
    logic [LW-1:0]  len;

    assign fl_ext = LCW'(frame_length_reg);

    always_comb
    begin
        if (fl_ext == '0)
            len_ext = LCW'(1);
        else if (fl_ext > LCW'(MAX_FRAME_BYTES))
            len_ext = LCW'(MAX_FRAME_BYTES);
        else
            len_ext = fl_ext;
    end

    assign len = len_ext[LW-1:0];

    // Byte position and end-of-frame detection.
    logic [AW-1:0] pos_reg;
    logic [LW-1:0] pos_inc;
    logic          last_now;
    logic          accept;
    logic          busy;

    // Stage A: byte waits for the store read.
    logic                       a_valid_reg;
    logic                       a_last_reg;
    logic [AW-1:0]              a_pos_reg;
    logic [erms_pkg::BYTE_W-1:0] a_byte_reg;
    logic                       fwd_reg;
    logic [erms_pkg::BYTE_W-1:0] fwd_byte_reg;
    logic [erms_pkg::BYTE_W-1:0] rdata_reg;
    logic [erms_pkg::BYTE_W-1:0] prev_byte;
    logic [erms_pkg::COUNT_W-1:0] diff_reg;
    logic [erms_pkg::COUNT_W-1:0] diff_next;

    // Stage P: frame count ready for the products.
    logic                        p_valid_reg;
    logic [erms_pkg::COUNT_W-1:0] p_count_reg;

    // Stage Q: products registered for the compare.
    logic                        q_valid_reg;
    logic [erms_pkg::COUNT_W-1:0] q_count_reg;
    logic [erms_pkg::LHS_W-1:0]  q_lhs_reg;
    logic [RW-1:0]               q_rhs_reg;

    // Decision state and output register.
    logic                        frame_seen_reg;
    logic [erms_pkg::RUN_W-1:0]  partial_run_reg;
    logic                        out_valid_reg;
    erms_pkg::action_t           out_action_reg;
    logic [erms_pkg::COUNT_W-1:0] out_count_reg;

    assign pos_inc  = LW'(pos_reg) + LW'(1);
    assign last_now = (pos_inc >= len);
    assign busy     = (a_valid_reg && a_last_reg) || p_valid_reg || q_valid_reg
                      || out_valid_reg;
    // A frame-ending byte waits until its result has a free path to the output.
    assign s_tready = !last_now || !busy;
    assign accept   = s_tvalid && s_tready;

    // Frame store.
    logic [erms_pkg::BYTE_W-1:0] frame_mem [MAX_FRAME_BYTES];

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
            frame_mem[a_pos_reg] <= a_byte_reg;
        if (accept)
            rdata_reg <= frame_mem[pos_reg];
    end

    // A read of the address being written this cycle takes the new byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_reg      <= a_valid_reg && (a_pos_reg == pos_reg);
            fwd_byte_reg <= a_byte_reg;
            a_pos_reg    <= pos_reg;
            a_byte_reg   <= s_tdata;
            a_last_reg   <= last_now;
        end
    end

    assign prev_byte = fwd_reg ? fwd_byte_reg : rdata_reg;
    assign diff_next = diff_reg + erms_pkg::COUNT_W'(prev_byte != a_byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            a_valid_reg <= 1'b0;
            diff_reg    <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                pos_reg <= last_now ? '0 : pos_inc[AW-1:0];
            a_valid_reg <= accept;
            p_valid_reg <= a_valid_reg && a_last_reg;
            if (a_valid_reg)
                diff_reg <= a_last_reg ? '0 : diff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && a_last_reg)
            p_count_reg <= diff_next;
    end

    // Products for the threshold test: count*100 against (dirty_percent+1)*length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            q_count_reg <= p_count_reg;
            q_lhs_reg   <= erms_pkg::LHS_W'(p_count_reg)
                           * erms_pkg::LHS_W'(erms_pkg::PERCENT_SCALE);
            q_rhs_reg   <= (RW'(dirty_percent_reg) + RW'(1)) * RW'(len);
        end
    end

    // Decision and result register.
    logic over_limit;
    assign over_limit = (CW'(q_lhs_reg) >= CW'(q_rhs_reg))
                        || (partial_run_reg >= partial_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_seen_reg  <= 1'b0;
            partial_run_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_action_reg  <= erms_pkg::ACT_NONE;
            out_count_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (q_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                out_count_reg <= frame_seen_reg ? q_count_reg : '0;
                if (!frame_seen_reg)
                begin
                    // The first frame has nothing to compare with.
                    frame_seen_reg  <= 1'b1;
                    out_action_reg  <= erms_pkg::ACT_FULL;
                    partial_run_reg <= '0;
                end
                else if (q_count_reg == '0)
                begin
                    out_action_reg <= erms_pkg::ACT_NONE;
                end
                else if (over_limit)
                begin
                    out_action_reg  <= erms_pkg::ACT_FULL;
                    partial_run_reg <= '0;
                end
                else
                begin
                    out_action_reg  <= erms_pkg::ACT_PARTIAL;
                    partial_run_reg <= partial_run_reg + erms_pkg::RUN_W'(1);
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_count_reg, out_action_reg};

endmodule : epaper_refresh_mode_selector
`default_nettype wire
